[design/tpap_pkg.sv]
`timescale 1ns / 1ps

package tpap_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int PRESSURE_BITS = 8;

	localparam int VAL_W  = 32;
	localparam int PROD_W = 2 * VAL_W;
	// clipped factor before the pressure multiply
	localparam int F_W    = PROD_W - FRAC_BITS;
	localparam int TOT_W  = F_W + VAL_W;

	// divider: magnitude of (z - low_bound) * slope over the bound span
	localparam int NUM_W      = PRESSURE_BITS + VAL_W;
	localparam int DIV_BPS    = 4;
	localparam int DIV_STAGES = (NUM_W + DIV_BPS - 1) / DIV_BPS;
	localparam int DIV_W      = DIV_STAGES * DIV_BPS;

	localparam int IN_DATA_W  = ((2 * VAL_W + PRESSURE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = VAL_W;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MOTION_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_CLIP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_CLIP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO_BOUND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI_BOUND = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO_FACT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI_FACT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_ENABLE   = 3'd7;

	typedef enum logic [2:0] {
		PSEL_LOW    = 3'b001,
		PSEL_HIGH   = 3'b010,
		PSEL_INTERP = 3'b100
	} psel_t;

	typedef struct packed {
		logic [F_W-1:0] f;
		psel_t          psel;
		logic           neg;
	} tpap_side_t;

	typedef struct packed {
		logic [DIV_W-1:0]         num;
		logic [PRESSURE_BITS-1:0] rem;
		logic [PRESSURE_BITS-1:0] dvs;
		tpap_side_t               side;
	} tpap_div_t;

endpackage

[design/tpap_div_pipe.sv]
`timescale 1ns / 1ps

module tpap_div_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tpap_pkg::tpap_div_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tpap_pkg::tpap_div_t out_data
);
	import tpap_pkg::*;

	// one restoring step: numerator shifts out at the top, quotient bit in at the bottom
	function automatic tpap_div_t div_step(input tpap_div_t w);
		logic [PRESSURE_BITS:0] t;
		logic                   qb;
		tpap_div_t              r;
		t  = {w.rem, w.num[DIV_W-1]};
		qb = (t >= {1'b0, w.dvs});
		if (qb) t = t - {1'b0, w.dvs};
		r      = w;
		r.rem  = t[PRESSURE_BITS-1:0];
		r.num  = {w.num[DIV_W-2:0], qb};
		return r;
	endfunction

	logic      [DIV_STAGES-1:0] v_q;
	logic      [DIV_STAGES:0]   rdy;
	tpap_div_t                  d_q [DIV_STAGES];
	tpap_div_t                  nxt [DIV_STAGES];

	assign rdy[DIV_STAGES] = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = v_q[DIV_STAGES-1];
	assign out_data  = d_q[DIV_STAGES-1];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic      prev_v;
		tpap_div_t prev_d;

		if (k == 0) begin : g_first
			assign prev_v = in_valid;
			assign prev_d = in_data;
		end else begin : g_next
			assign prev_v = v_q[k-1];
			assign prev_d = d_q[k-1];
		end

		assign rdy[k] = !v_q[k] || rdy[k+1];

		always_comb begin
			tpap_div_t w;
			w = prev_d;
			for (int b = 0; b < DIV_BPS; b++) w = div_step(w);
			nxt[k] = w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_q[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prev_v) begin
				d_q[k] <= nxt[k];
			end
		end
	end

endmodule

[design/touchpad_accel_profile_unit.sv]
`timescale 1ns / 1ps
// touchpad acceleration profile unit
// s_* stream: one motion event per word, m_* stream: one acceleration factor per word.
// the factor is velocity times motion_gain, clipped above at the upper clip factor times
// accel_limit and below at the lower clip factor, then optionally scaled by an
// interpolated pressure factor; all but pressure unsigned q16.16; result saturates at all ones.
// cfg_* channel writes one register per handshake (index 0..7), always ready; write only
// while no event is in flight.
// pipeline from input handshake to output valid: two product/clip stages, ten stages of
// the radix-16 pressure divider, three stages for the pressure multiply.
// throughput: one event per cycle while m_tready is high; every stage holds a valid bit
// and loads when empty or when the stage after it moves, so bubbles fill up behind a
// stalled output. when m_tready stays low the output word holds, the pipeline fills and
// s_tready drops once all 15 stages are occupied; nothing is dropped or repeated.
// reset clears all valid bits and loads the register defaults.
module touchpad_accel_profile_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// finger_velocity[31:0], accel_limit[63:32], pressure[71:64]
	input  logic [tpap_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// accel_factor[31:0]
	output logic [tpap_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tpap_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tpap_pkg::VAL_W-1:0]       cfg_data
);
	import tpap_pkg::*;

	logic [VAL_W-1:0]         motion_gain_q, upper_clip_q, lower_clip_q;
	logic [PRESSURE_BITS-1:0] press_lo_q, press_hi_q;
	logic [VAL_W-1:0]         press_lo_fact_q, press_hi_fact_q;
	logic                     press_en_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_gain_q   <= VAL_W'(6607);
			upper_clip_q    <= VAL_W'(114688);
			lower_clip_q    <= VAL_W'(65536);
			press_lo_q      <= PRESSURE_BITS'(30);
			press_hi_q      <= PRESSURE_BITS'(160);
			press_lo_fact_q <= VAL_W'(65536);
			press_hi_fact_q <= VAL_W'(65536);
			press_en_q      <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MOTION_GAIN:    motion_gain_q   <= cfg_data;
				REG_UPPER_CLIP:     upper_clip_q    <= cfg_data;
				REG_LOWER_CLIP:     lower_clip_q    <= cfg_data;
				REG_PRESS_LO_BOUND: press_lo_q      <= cfg_data[PRESSURE_BITS-1:0];
				REG_PRESS_HI_BOUND: press_hi_q      <= cfg_data[PRESSURE_BITS-1:0];
				REG_PRESS_LO_FACT:  press_lo_fact_q <= cfg_data;
				REG_PRESS_HI_FACT:  press_hi_fact_q <= cfg_data;
				REG_PRESS_ENABLE:   press_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [VAL_W-1:0]         vel, acc;
	logic [PRESSURE_BITS-1:0] z;
	assign vel = s_tdata[VAL_W-1:0];
	assign acc = s_tdata[2*VAL_W-1:VAL_W];
	assign z   = s_tdata[2*VAL_W+PRESSURE_BITS-1:2*VAL_W];

	// stage handshake chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic div_in_ready, div_out_valid;
	tpap_div_t div_in, div_out;

	assign rdy5     = !v_s5 || m_tready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || div_in_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= div_out_valid;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: products and pressure numerator
	logic [PROD_W-1:0]        prod_f_s1, prod_u_s1;
	logic [NUM_W-1:0]         num_s1;
	logic [PRESSURE_BITS-1:0] dvs_s1;
	psel_t                    psel_s1;
	logic                     neg_s1;

	logic                     slope_neg;
	logic [VAL_W-1:0]         slope_abs;
	logic [PRESSURE_BITS-1:0] z_off;
	psel_t                    psel_c;

	always_comb begin
		slope_neg = press_hi_fact_q < press_lo_fact_q;
		slope_abs = slope_neg ? press_lo_fact_q - press_hi_fact_q
		                      : press_hi_fact_q - press_lo_fact_q;
		z_off     = z - press_lo_q;
		// low bound is tested first, so crossed bounds never interpolate
		if (z <= press_lo_q)      psel_c = PSEL_LOW;
		else if (z >= press_hi_q) psel_c = PSEL_HIGH;
		else                      psel_c = PSEL_INTERP;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			prod_f_s1 <= PROD_W'(vel) * PROD_W'(motion_gain_q);
			prod_u_s1 <= PROD_W'(upper_clip_q) * PROD_W'(acc);
			num_s1    <= NUM_W'(z_off) * NUM_W'(slope_abs);
			dvs_s1    <= press_hi_q - press_lo_q;
			psel_s1   <= psel_c;
			neg_s1    <= slope_neg;
		end
	end

	// stage 2: clip
	logic [F_W-1:0] f_raw, upper, f_clip;
	always_comb begin
		f_raw = prod_f_s1[PROD_W-1:FRAC_BITS];
		upper = prod_u_s1[PROD_W-1:FRAC_BITS];
		if (f_raw > upper)                   f_clip = upper;
		else if (f_raw < F_W'(lower_clip_q)) f_clip = F_W'(lower_clip_q);
		else                                 f_clip = f_raw;
	end

	tpap_div_t div_s2;
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			div_s2.num       <= DIV_W'(num_s1);
			div_s2.rem       <= '0;
			div_s2.dvs       <= dvs_s1;
			div_s2.side.f    <= f_clip;
			div_s2.side.psel <= psel_s1;
			div_s2.side.neg  <= neg_s1;
		end
	end
	assign div_in = div_s2;

	tpap_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.in_data   (div_in),
		.out_valid (div_out_valid),
		.out_ready (rdy3),
		.out_data  (div_out)
	);

	// stage 3: pressure factor
	logic [VAL_W-1:0] quo, pfact;
	logic [F_W-1:0]   f_s3;
	logic [VAL_W-1:0] p_s3;
	always_comb begin
		quo = div_out.num[VAL_W-1:0];
		case (div_out.side.psel)
			PSEL_LOW:    pfact = press_lo_fact_q;
			PSEL_HIGH:   pfact = press_hi_fact_q;
			PSEL_INTERP: pfact = div_out.side.neg ? press_lo_fact_q - quo
			                                      : press_lo_fact_q + quo;
			default:     pfact = press_lo_fact_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy3 && div_out_valid) begin
			f_s3 <= div_out.side.f;
			p_s3 <= pfact;
		end
	end

	// stage 4: partial products of the 48 x 32 pressure multiply
	logic [PROD_W-1:0] pl_s4;
	logic [F_W-1:0]    ph_s4;
	logic [F_W-1:0]    f_s4;
	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			pl_s4 <= PROD_W'(f_s3[VAL_W-1:0]) * PROD_W'(p_s3);
			ph_s4 <= F_W'(f_s3[F_W-1:VAL_W]) * F_W'(p_s3);
			f_s4  <= f_s3;
		end
	end

	// stage 5: sum, shift, saturate
	logic [TOT_W-1:0] total;
	logic [VAL_W-1:0] res;
	always_comb begin
		total = (TOT_W'(ph_s4) << VAL_W) + TOT_W'(pl_s4);
		if (press_en_q) begin
			if (total[TOT_W-1:FRAC_BITS+VAL_W] != '0) res = '1;
			else                                      res = total[FRAC_BITS+VAL_W-1:FRAC_BITS];
		end else begin
			if (f_s4[F_W-1:VAL_W] != '0) res = '1;
			else                         res = f_s4[VAL_W-1:0];
		end
	end

	logic [VAL_W-1:0] res_s5;
	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			res_s5 <= res;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = res_s5;

endmodule

[design/tpap_checker.sv]
`timescale 1ns / 1ps

module tpap_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tpap_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);
	import tpap_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// an open output means the whole pipe can move
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked with output ready");

	// input only backs up behind a stalled result
	a_block_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input blocked without output stall");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind touchpad_accel_profile_unit tpap_checker u_tpap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
